// ===== sv/udp_echo_header_reflector_defines.svh =====
// Assertion macros for the UDP echo header reflector.
`ifndef UDP_ECHO_HEADER_REFLECTOR_DEFINES_SVH
`define UDP_ECHO_HEADER_REFLECTOR_DEFINES_SVH

// Check that cond implies cons in the same cycle.
`define UER_CHECK(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that cond implies cons in the next cycle.
`define UER_CHECK_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/uer_pkg.sv =====
// Types, constants and header byte mapping for the UDP echo header reflector.
`default_nettype none

package uer_pkg;

    localparam int unsigned HDR_LEN  = 42;
    localparam int unsigned IP_START = 14;
    localparam int unsigned IP_END   = 34;
    localparam int unsigned CKS_HI   = 24;
    localparam int unsigned CKS_LO   = 25;

    typedef logic [5:0]  t_pos;
    typedef logic [7:0]  t_byte;
    typedef logic [16:0] t_acc;
    typedef logic [15:0] t_cks;

    typedef enum logic [1:0] {
        K_MEM,
        K_CKS_HI,
        K_CKS_LO,
        K_ZERO
    } t_kind;

    typedef struct packed {
        t_pos  idx;
        t_kind kind;
    } t_src;

    function automatic t_src src_map(input t_pos i, input logic rw);
        t_src s;
        s.idx  = i;
        s.kind = K_MEM;
        if (rw) begin
            if (i < 6'd6) begin
                s.idx = i + 6'd6;
            end else if (i < 6'd12) begin
                s.idx = i - 6'd6;
            end else if (i == 6'(CKS_HI)) begin
                s.kind = K_CKS_HI;
            end else if (i == 6'(CKS_LO)) begin
                s.kind = K_CKS_LO;
            end else if (i >= 6'd26 && i < 6'd30) begin
                s.idx = i + 6'd4;
            end else if (i >= 6'd30 && i < 6'd34) begin
                s.idx = i - 6'd4;
            end else if (i == 6'd34 || i == 6'd35) begin
                s.idx = i + 6'd2;
            end else if (i == 6'd36 || i == 6'd37) begin
                s.idx = i - 6'd2;
            end else if (i == 6'd40 || i == 6'd41) begin
                s.kind = K_ZERO;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/udp_echo_header_reflector.sv =====
// UDP echo header reflector: header buffer, rewrite drain and pass-through.
//
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in_byte, i_in_last
// out       output     o_out_valid / i_out_stall  o_out_byte, o_out_last
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_rewrite_enable
//
// Header bytes 1..42 are taken one per cycle into the header memory.
// The header drain then reads the memory one byte per cycle unless the output stalls,
// 42 bytes (or the short frame length), input stalled; the single read port sets this.
// Payload input resumes once the read stage is empty, one byte per cycle unless stalled.
// Output stalls hold the read stage and the output register; no byte is lost.
// Reset is synchronous, active low, and clears control state only.
`default_nettype none
`include "udp_echo_header_reflector_defines.svh"

module udp_echo_header_reflector (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output      logic         o_in_stall,
    input  wire uer_pkg::t_byte i_in_byte,
    input  wire logic         i_in_last,
    output      logic         o_out_valid,
    input  wire logic         i_out_stall,
    output      uer_pkg::t_byte o_out_byte,
    output      logic         o_out_last,
    input  wire logic         i_cfg_valid,
    output      logic         o_cfg_ready,
    input  wire logic         i_cfg_rewrite_enable
);

    import uer_pkg::*;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_DRAIN,
        S_PASS
    } t_state;

    t_byte  r_mem [HDR_LEN];

    t_state r_state;
    t_pos   r_pos;
    t_acc   r_acc;
    t_cks   r_cks;
    logic   r_rw;
    logic   r_cfg_rw;
    t_pos   r_cnt;
    t_pos   r_n;
    logic   r_end_last;
    logic   r_to_pass;

    logic   r_rd_valid;
    t_byte  r_rd_data;
    t_kind  r_rd_kind;
    logic   r_rd_last;

    logic   r_out_valid;
    t_byte  r_out_byte;
    logic   r_out_last;

    logic   out_load;
    logic   issue;
    logic   in_accept;
    logic   drain_end;
    logic   in_ip;
    t_src   src;
    t_cks   add;
    logic [17:0] sum;
    t_acc   n_acc;
    t_acc   f1;
    t_acc   f2;
    t_byte  rd_byte;

    assign o_cfg_ready = 1'b1;
    assign out_load    = !r_out_valid || !i_out_stall;
    assign issue       = (r_state == S_DRAIN) && (!r_rd_valid || out_load);
    assign drain_end   = issue && (r_cnt == r_n - 6'd1);

    always_comb begin
        case (r_state)
            S_COLLECT: o_in_stall = 1'b0;
            S_DRAIN:   o_in_stall = 1'b1;
            S_PASS:    o_in_stall = !(out_load && !r_rd_valid);
            default:   o_in_stall = 1'b1;
        endcase
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign src       = src_map(r_cnt, r_rw);

    assign in_ip = (r_pos >= 6'(IP_START)) && (r_pos < 6'(IP_END)) &&
                   (r_pos != 6'(CKS_HI)) && (r_pos != 6'(CKS_LO));
    assign add   = r_pos[0] ? {8'h00, i_in_byte} : {i_in_byte, 8'h00};
    assign sum   = {1'b0, r_acc} + {2'b00, add};
    assign n_acc = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
    assign f1    = {1'b0, r_acc[15:0]} + {16'd0, r_acc[16]};
    assign f2    = {1'b0, f1[15:0]} + {16'd0, f1[16]};

    always_comb begin
        case (r_rd_kind)
            K_MEM:    rd_byte = r_rd_data;
            K_CKS_HI: rd_byte = r_cks[15:8];
            K_CKS_LO: rd_byte = r_cks[7:0];
            K_ZERO:   rd_byte = 8'h00;
            default:  rd_byte = r_rd_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COLLECT && in_accept) begin
            r_mem[r_pos] <= i_in_byte;
        end
        if (issue) begin
            r_rd_data <= r_mem[src.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_pos       <= '0;
            r_acc       <= '0;
            r_cfg_rw    <= 1'b1;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_rw <= i_cfg_rewrite_enable;
            end

            case (r_state)
                S_COLLECT: begin
                    if (in_accept) begin
                        if (r_pos == 6'(HDR_LEN - 1) || i_in_last) begin
                            r_state    <= S_DRAIN;
                            r_cnt      <= '0;
                            r_n        <= r_pos + 6'd1;
                            r_cks      <= ~f2[15:0];
                            r_pos      <= '0;
                            r_acc      <= '0;
                            if (r_pos == 6'(HDR_LEN - 1)) begin
                                r_rw       <= r_cfg_rw;
                                r_end_last <= i_in_last;
                                r_to_pass  <= !i_in_last;
                            end else begin
                                r_rw       <= 1'b0;
                                r_end_last <= 1'b1;
                                r_to_pass  <= 1'b0;
                            end
                        end else begin
                            r_pos <= r_pos + 6'd1;
                            if (in_ip) begin
                                r_acc <= n_acc;
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    if (issue) begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                    if (drain_end) begin
                        r_state <= r_to_pass ? S_PASS : S_COLLECT;
                    end
                end
                S_PASS: begin
                    if (in_accept && i_in_last) begin
                        r_state <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase

            if (issue) begin
                r_rd_valid <= 1'b1;
                r_rd_kind  <= src.kind;
                r_rd_last  <= (r_cnt == r_n - 6'd1) && r_end_last;
            end else if (r_rd_valid && out_load) begin
                r_rd_valid <= 1'b0;
            end

            if (out_load) begin
                if (r_rd_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= rd_byte;
                    r_out_last  <= r_rd_last;
                end else if (r_state == S_PASS && in_accept) begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= i_in_byte;
                    r_out_last  <= i_in_last;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    `UER_CHECK(a_pos_in_range, r_state == S_COLLECT, r_pos < 6'(HDR_LEN), "header position overflow")
    `UER_CHECK(a_cnt_in_range, r_state == S_DRAIN, r_cnt < r_n, "drain count past header length")
    `UER_CHECK_NEXT(a_drain_holds, r_state == S_DRAIN && !issue, r_state == S_DRAIN, "drain left early")
    `UER_CHECK(a_pass_order, r_state == S_PASS && in_accept, !r_rd_valid, "payload overtook header")

endmodule

`default_nettype wire
